[rtl/qpht_pkg.sv]
// qpht_pkg: shared widths, status codes, table entry layout and the
// command/status structs between the probe controller and the datapath
// no dependencies
package qpht_pkg;

   localparam int KEY_W      = 31;
   localparam int VAL_W      = 32;
   localparam int STATUS_W   = 2;
   localparam int SLOT_OUT_W = 4;

   typedef enum logic [STATUS_W-1:0] {
      RSP_INSERTED = 2'd0,
      RSP_FULL     = 2'd1,
      RSP_FOUND    = 2'd2,
      RSP_MISSING  = 2'd3
   } rsp_status_type;

   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } entry_type;

   // controller -> datapath
   typedef struct packed {
      logic           load;        // capture item, start key reduction
      logic           reduce;      // one step of the key remainder mod SLOTS
      logic           rd;          // read table entry at current probe slot
      logic           advance;     // move to the next quadratic probe slot
      logic           wr_insert;   // write item into current probe slot
      logic           clr_step;    // clear one entry after reset
      logic           rsp_en;      // register a result for the strobe
      rsp_status_type rsp_status;
   } qpht_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic mode_search;
      logic reduce_last;
      logic entry_valid;
      logic key_match;
      logic last_probe;
      logic clear_last;
   } qpht_sts_type;

endpackage

[rtl/quadratic_probe_hash_table.sv]
// quadratic_probe_hash_table: top level of the open-addressing hash table
// with quadratic probing; joins qpht_ctrl and qpht_datapath
// depends on qpht_pkg, qpht_ctrl, qpht_datapath
//
//  channel   ports                                      handshake
//  --------  -----------------------------------------  --------------------------
//  request   req_mode, req_key, req_value               taken when start && !busy
//  result    rsp_status, rsp_slot, rsp_found_value      one-cycle strobe rsp_valid
//
// after reset the table is swept clear, one entry a cycle, with busy high
// an item holds busy through key mod SLOTS by reciprocal multiply (a quotient step,
// then a remainder step), then one memory read and one check per probe, probes
// from 1 to SLOTS; a new item is taken only once busy is low again; the registered
// read port of the table memory splits each probe into a read and a check state
// the result strobe comes the cycle after the last check; busy is already low then
// the receiver cannot stall: each result is shown for exactly one cycle
module quadratic_probe_hash_table #(
   parameter int SLOTS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_mode,
   input  logic [qpht_pkg::KEY_W-1:0]      req_key,
   input  logic [qpht_pkg::VAL_W-1:0]      req_value,
   output logic                            rsp_valid,
   output logic [qpht_pkg::STATUS_W-1:0]   rsp_status,
   output logic [qpht_pkg::SLOT_OUT_W-1:0] rsp_slot,
   output logic [qpht_pkg::VAL_W-1:0]      rsp_found_value
);
   import qpht_pkg::*;

   qpht_cmd_type cmd;   // controller commands
   qpht_sts_type sts;   // datapath status

   // sequencer: clear sweep, key reduction, probe read/check loop
   qpht_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // remainder unit, probe address, table memory and result registers
   qpht_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_mode        (req_mode),
      .req_key         (req_key),
      .req_value       (req_value),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_slot        (rsp_slot),
      .rsp_found_value (rsp_found_value)
   );

`ifndef NO_ASSERTIONS
   // an accepted item keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("item accepted but block not busy");

   // a result only follows a cycle of work on an item
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without preceding work");

   // full and not-found results carry zero slot and value
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == RSP_FULL || rsp_status == RSP_MISSING))
      |-> (rsp_slot == '0 && rsp_found_value == '0))
      else $error("nonzero slot or value on a miss");
`endif

endmodule

[rtl/qpht_datapath.sv]
// qpht_datapath: key reduction, quadratic probe address, table memory
// and result registers; driven by qpht_ctrl
// depends on qpht_pkg
module qpht_datapath #(
   parameter int SLOTS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_mode,
   input  logic [qpht_pkg::KEY_W-1:0]      req_key,
   input  logic [qpht_pkg::VAL_W-1:0]      req_value,
   input  qpht_pkg::qpht_cmd_type          cmd,
   output qpht_pkg::qpht_sts_type          sts,
   output logic                            rsp_valid,
   output logic [qpht_pkg::STATUS_W-1:0]   rsp_status,
   output logic [qpht_pkg::SLOT_OUT_W-1:0] rsp_slot,
   output logic [qpht_pkg::VAL_W-1:0]      rsp_found_value
);
   import qpht_pkg::*;

   localparam int SW  = $clog2(SLOTS);
   // quotient = (key * RECIP) >> RSH, exact for every KEY_W-bit key
   localparam int RSH = KEY_W + SW;
   localparam logic [KEY_W:0] RECIP =
      (KEY_W+1)'(((64'd1 << RSH) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));

   logic                   mode_ff;
   logic [KEY_W-1:0]       key_ff;
   logic [VAL_W-1:0]       value_ff;
   logic                   red_phase_ff;
   logic [SW-1:0]          quot_lo_ff;
   logic [SW-1:0]          slot_ff, slot_in;
   logic [SW-1:0]          step_ff, step_in;
   logic [SW-1:0]          probe_cnt_ff;
   logic [SW-1:0]          clr_addr_ff;
   entry_type              rd_entry_ff;
   logic                   rsp_valid_ff;
   rsp_status_type         rsp_status_ff;
   logic [SLOT_OUT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [VAL_W-1:0]       rsp_value_ff;

   logic [2*KEY_W:0]       prod;
   logic [SW-1:0]          rem_next;
   logic [SW:0]            slot_sum, step_sum;
   logic [SW+SLOT_OUT_W-1:0] slot_ext;

   entry_type              mem [SLOTS];
   logic                   mem_we;
   logic [SW-1:0]          mem_waddr;
   entry_type              mem_wdata;

   // key mod SLOTS: reciprocal multiply first, then key - quotient*SLOTS,
   // only the low SW bits are needed since the remainder is below SLOTS
   assign prod     = {{(KEY_W+1){1'b0}}, key_ff} * {{KEY_W{1'b0}}, RECIP};
   assign rem_next = key_ff[SW-1:0] - SW'(quot_lo_ff * SW'(SLOTS));

   // (k + (p+1)^2) = (k + p^2) + (2p+1), both terms kept below SLOTS
   always_comb begin
      slot_sum = {1'b0, slot_ff} + {1'b0, step_ff};
      if (slot_sum >= (SW+1)'(SLOTS)) begin
         slot_in = SW'(slot_sum - (SW+1)'(SLOTS));
      end else begin
         slot_in = slot_sum[SW-1:0];
      end
      step_sum = {1'b0, step_ff} + (SW+1)'(2);
      if (step_sum >= (SW+1)'(SLOTS)) begin
         step_in = SW'(step_sum - (SW+1)'(SLOTS));
      end else begin
         step_in = step_sum[SW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff      <= req_mode;
         key_ff       <= req_key;
         value_ff     <= req_value;
         red_phase_ff <= 1'b0;
         slot_ff      <= '0;
         step_ff      <= SW'(1);
         probe_cnt_ff <= '0;
      end else if (cmd.reduce) begin
         red_phase_ff <= 1'b1;
         if (!red_phase_ff) begin
            quot_lo_ff <= prod[RSH +: SW];
         end else begin
            slot_ff    <= rem_next;
         end
      end else if (cmd.advance) begin
         slot_ff      <= slot_in;
         step_ff      <= step_in;
         probe_cnt_ff <= probe_cnt_ff + SW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_addr_ff <= clr_addr_ff + SW'(1);
      end
   end

   // table memory: one write port, one registered read port
   assign mem_we    = cmd.clr_step | cmd.wr_insert;
   assign mem_waddr = cmd.clr_step ? clr_addr_ff : slot_ff;
   assign mem_wdata = cmd.clr_step ? entry_type'('0) : entry_type'{1'b1, key_ff, value_ff};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rd_entry_ff <= mem[slot_ff];
      end
   end

   assign sts.mode_search = mode_ff;
   assign sts.reduce_last = red_phase_ff;
   assign sts.entry_valid = rd_entry_ff.valid;
   assign sts.key_match   = (rd_entry_ff.key == key_ff);
   assign sts.last_probe  = (probe_cnt_ff == SW'(SLOTS - 1));
   assign sts.clear_last  = (clr_addr_ff == SW'(SLOTS - 1));

   // result registers
   assign slot_ext = {{SLOT_OUT_W{1'b0}}, slot_ff};

   always_comb begin
      if (cmd.rsp_status == RSP_INSERTED || cmd.rsp_status == RSP_FOUND) begin
         rsp_slot_in = slot_ext[SLOT_OUT_W-1:0];
      end else begin
         rsp_slot_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.rsp_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_en) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_value_ff  <= (cmd.rsp_status == RSP_FOUND) ? rd_entry_ff.value : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_found_value = rsp_value_ff;

endmodule

[rtl/qpht_ctrl.sv]
// qpht_ctrl: state machine sequencing clear, key reduction and probes
// depends on qpht_pkg
module qpht_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  qpht_pkg::qpht_sts_type sts,
   output qpht_pkg::qpht_cmd_type cmd
);
   import qpht_pkg::*;

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_REDUCE = 5'b00100,
      ST_READ   = 5'b01000,
      ST_CHECK  = 5'b10000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.rsp_status = RSP_MISSING;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            cmd.reduce = 1'b1;
            if (sts.reduce_last) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!sts.mode_search) begin
               if (!sts.entry_valid) begin
                  cmd.wr_insert  = 1'b1;
                  cmd.rsp_en     = 1'b1;
                  cmd.rsp_status = RSP_INSERTED;
                  state_in       = ST_IDLE;
               end else if (sts.last_probe) begin
                  cmd.rsp_en     = 1'b1;
                  cmd.rsp_status = RSP_FULL;
                  state_in       = ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = ST_READ;
               end
            end else begin
               if (!sts.entry_valid || (sts.last_probe && !sts.key_match)) begin
                  cmd.rsp_en     = 1'b1;
                  cmd.rsp_status = RSP_MISSING;
                  state_in       = ST_IDLE;
               end else if (sts.key_match) begin
                  cmd.rsp_en     = 1'b1;
                  cmd.rsp_status = RSP_FOUND;
                  state_in       = ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

`ifndef NO_ASSERTIONS
   // a table write only happens as an insert hitting an empty slot, or during clear
   a_write_only_on_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_insert |-> (state_ff == ST_CHECK && !sts.mode_search && !sts.entry_valid))
      else $error("table write outside an insert into an empty slot");

   // each probe read is followed by its check
   a_read_then_check: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (state_ff == ST_CHECK))
      else $error("probe read not followed by check");
`endif

endmodule
